[sv/tpr_pkg.sv]
// Shared types and constants for the time payload record parser.
package tpr_pkg;

   localparam int unsigned RecLen     = 24;
   localparam int unsigned IdxWidth   = 5;
   localparam logic [IdxWidth-1:0] IDX_MAX  = 5'd31;
   localparam logic [IdxWidth-1:0] IDX_LAST = 5'(RecLen - 1);

   localparam logic [31:0] SECONDS_PER_DAY = 32'd86400;
   localparam logic [7:0]  CODE_MAX        = 8'd8;
   localparam logic [7:0]  HDR_VERSION     = 8'd1;

   // "OTTC", offset 0 in the lowest byte
   localparam logic [3:0][7:0] MAGIC = {8'h43, 8'h54, 8'h54, 8'h4F};

   localparam logic [7:0] KIND_SYNC    = 8'd1;
   localparam logic [7:0] KIND_PROBE   = 8'd2;
   localparam logic [7:0] KIND_TIME    = 8'd3;
   localparam logic [7:0] KIND_REPLY   = 8'd4;

   localparam logic [7:0] FMT_NONE     = 8'd0;
   localparam logic [7:0] FMT_LOCAL    = 8'd1;
   localparam logic [7:0] FMT_UTC      = 8'd2;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_MALFORMED = 2'd1,
      STATUS_BAD_LEN   = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      logic [31:0] second_of_day;
      logic [63:0] challenge;
      logic [7:0]  time_format;
      logic [7:0]  reply_code;
      logic [7:0]  record_kind;
   } rec_fields_type;

   localparam int unsigned RspDataWidth = $bits(rec_fields_type);

endpackage

[sv/tpr_in_reg.sv]
// Input register stage: holds one byte transaction until the parser takes it.
module tpr_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tpr_pkg::byte_item_type in_item,
   input  logic                   take,
   output logic                   hold_valid,
   output tpr_pkg::byte_item_type hold_item
);
   import tpr_pkg::*;

   logic          valid_ff, valid_in;
   byte_item_type item_ff;

   // free when empty or when the held byte leaves this cycle
   assign in_ready = !valid_ff || take;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

[sv/tpr_parser.sv]
// Record field capture, header/tail tracking and end-of-record checks.
module tpr_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  tpr_pkg::byte_item_type  item,
   output tpr_pkg::status_type     status,
   output tpr_pkg::rec_fields_type fields
);
   import tpr_pkg::*;

   logic [IdxWidth-1:0] idx_ff, idx_in;
   logic                header_good_ff, header_good_in;
   logic                tail_clear_ff, tail_clear_in;
   logic [7:0]          kind_ff, kind_in;
   logic [7:0]          code_ff, code_in;
   logic [7:0]          fmt_ff, fmt_in;
   logic [63:0]         chal_ff, chal_in;
   logic [31:0]         sec_ff, sec_in;
   logic                content_ok;
   logic                tail_ok;

   always_comb begin
      idx_in         = (idx_ff < IDX_MAX) ? idx_ff + 5'd1 : idx_ff;
      header_good_in = header_good_ff;
      tail_clear_in  = tail_clear_ff;
      kind_in        = kind_ff;
      code_in        = code_ff;
      fmt_in         = fmt_ff;
      chal_in        = chal_ff;
      sec_in         = sec_ff;
      case (idx_ff) inside
         [5'd0:5'd3]: begin
            if (item.data != MAGIC[idx_ff[1:0]]) header_good_in = 1'b0;
         end
         5'd4: begin
            if (item.data != HDR_VERSION) header_good_in = 1'b0;
         end
         5'd5:          kind_in = item.data;
         5'd6:          code_in = item.data;
         5'd7:          fmt_in  = item.data;
         [5'd8:5'd15]:  chal_in[{idx_ff[2:0], 3'b000} +: 8] = item.data;
         [5'd16:5'd19]: sec_in[{idx_ff[1:0], 3'b000} +: 8]  = item.data;
         [5'd20:5'd23]: begin
            if (item.data != 8'd0) tail_clear_in = 1'b0;
         end
         default: ;
      endcase
   end

   // Per-kind content rules on the captured fields
   always_comb begin
      case (kind_ff)
         KIND_SYNC:  content_ok = code_ff == 8'd0 && fmt_ff == FMT_NONE &&
                                  chal_ff == 64'd0 && sec_ff == 32'd0;
         KIND_PROBE: content_ok = code_ff == 8'd0 && fmt_ff == FMT_NONE &&
                                  chal_ff != 64'd0 && sec_ff == 32'd0;
         KIND_TIME:  content_ok = code_ff == 8'd0 &&
                                  (fmt_ff == FMT_LOCAL || fmt_ff == FMT_UTC) &&
                                  chal_ff != 64'd0 && sec_ff < SECONDS_PER_DAY;
         KIND_REPLY: content_ok = fmt_ff == FMT_NONE && sec_ff == 32'd0 &&
                                  (code_ff != 8'd0 || chal_ff != 64'd0);
         default:    content_ok = 1'b0;
      endcase
      if (code_ff > CODE_MAX) content_ok = 1'b0;
   end

   // the last tail byte is the current one when the length is right
   assign tail_ok = tail_clear_ff && item.data == 8'd0;

   always_comb begin
      fields = '0;
      if (idx_ff != IDX_LAST) begin
         status = STATUS_BAD_LEN;
      end else if (!header_good_ff || !tail_ok || !content_ok) begin
         status = STATUS_MALFORMED;
      end else begin
         status               = STATUS_OK;
         fields.record_kind   = kind_ff;
         fields.reply_code    = code_ff;
         fields.time_format   = fmt_ff;
         fields.challenge     = chal_ff;
         fields.second_of_day = sec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && item.last)) begin
         idx_ff         <= '0;
         header_good_ff <= 1'b1;
         tail_clear_ff  <= 1'b1;
         kind_ff        <= '0;
         code_ff        <= '0;
         fmt_ff         <= '0;
         chal_ff        <= '0;
         sec_ff         <= '0;
      end else if (step) begin
         idx_ff         <= idx_in;
         header_good_ff <= header_good_in;
         tail_clear_ff  <= tail_clear_in;
         kind_ff        <= kind_in;
         code_ff        <= code_in;
         fmt_ff         <= fmt_in;
         chal_ff        <= chal_in;
         sec_ff         <= sec_in;
      end
   end

endmodule

[sv/time_payload_record_parser.sv]
// Top level of the time payload record parser.
//
// Takes a 24-byte time record one byte per req transaction, offset zero first,
// with req_tlast on the final byte, and returns one rsp transaction per record
// on that final byte. Throughput is one byte per clock while no flagged byte
// waits: a byte is registered in the input stage, then checked and captured
// by the parser, and a record's result is loaded into the output register as
// its last byte leaves the input stage. Bytes that are not flagged last never
// wait on the result side; a flagged byte waits only while a previous result
// is still held in the output register and not taken in that cycle. The status
// in rsp_tuser is OK, MALFORMED (bad magic or version, nonzero tail, or a
// kind-specific rule broken) or BAD_LEN (flag not on the 24th byte); for any
// status other than OK every field in rsp_tdata reads zero. After each
// flagged byte the parser returns to its reset state for the next record.
module time_payload_record_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [tpr_pkg::RspDataWidth-1:0] rsp_tdata,
   // [7:0] record_kind, [15:8] reply_code, [23:16] time_format,
   // [87:24] challenge, [119:88] second_of_day
   output logic [1:0]   rsp_tuser    // [1:0] status
);
   import tpr_pkg::*;

   byte_item_type  in_item;
   byte_item_type  hold_item;
   logic           hold_valid;
   logic           out_free;
   logic           take;
   logic           load;
   status_type     status;
   rec_fields_type fields;

   logic           rsp_valid_ff, rsp_valid_in;
   status_type     rsp_status_ff;
   rec_fields_type rsp_fields_ff;

   assign in_item.data = req_tdata;
   assign in_item.last = req_tlast;

   tpr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   // Advance a byte when it makes no result, or when the output register can
   // take the result this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign take     = hold_valid && (!hold_item.last || out_free);
   assign load     = take && hold_item.last;

   tpr_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (take),
      .item   (hold_item),
      .status (status),
      .fields (fields)
   );

   // Hold the result until the consumer takes it.
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= status;
         rsp_fields_ff <= fields;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_fields_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

[verif/time_payload_record_parser_test.sv]
// Self-checking testbench for the time payload record parser: random stream stalls, record checks.
module time_payload_record_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tpr_pkg::*;

   // Cycles without any accepted transaction before the run is declared hung.
   localparam int unsigned StallLimit  = 2000;
   // Cycles to let the output register drain once nothing is awaited.
   localparam int unsigned DrainCycles = 10;
   // Random part: at least this many bytes and this many records.
   localparam int unsigned RandomBytes   = 175;
   localparam int unsigned RandomRecords = 6;
   // Window of cycles in which neither side idles.
   localparam int unsigned CalmStart = 300;
   localparam int unsigned CalmEnd   = 500;

   typedef struct {
      status_type     status;
      rec_fields_type fields;
   } parsed_record_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata  = '0;   // [7:0] data_byte
   logic         req_tlast  = 1'b0; // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   // [7:0] record_kind, [15:8] reply_code, [23:16] time_format,
   // [87:24] challenge, [119:88] second_of_day
   logic [1:0]   rsp_tuser;         // [1:0] status

   byte_item_type     pending_bytes[$];
   parsed_record_type awaited_records[$];
   logic [7:0]        rec_bytes [0:47];

   int unsigned fail_count   = 0;
   int unsigned stall_cycles = 0;
   int unsigned cycle_count  = 0;

   // Parser state as predicted from the byte stream.
   logic [4:0]  pr_index       = '0;
   logic        pr_header_good = 1'b1;
   logic        pr_tail_clear  = 1'b1;
   logic [7:0]  pr_kind        = '0;
   logic [7:0]  pr_code        = '0;
   logic [7:0]  pr_format      = '0;
   logic [63:0] pr_challenge   = '0;
   logic [31:0] pr_seconds     = '0;

   time_payload_record_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Per-kind content rules, checked only on a record of exactly 24 bytes.
   function automatic logic kind_rules_met();
      if (pr_code > CODE_MAX) return 1'b0;
      case (pr_kind)
         KIND_SYNC:  return pr_code == 0 && pr_format == FMT_NONE && pr_challenge == 0
                            && pr_seconds == 0;
         KIND_PROBE: return pr_code == 0 && pr_format == FMT_NONE && pr_challenge != 0
                            && pr_seconds == 0;
         KIND_TIME:  return pr_code == 0 && (pr_format == FMT_LOCAL || pr_format == FMT_UTC)
                            && pr_challenge != 0 && pr_seconds < SECONDS_PER_DAY;
         KIND_REPLY: return pr_format == FMT_NONE && pr_seconds == 0
                            && (pr_code != 0 || pr_challenge != 0);
         default:    return 1'b0;
      endcase
   endfunction

   // Advance the predicted parser by one accepted byte; a flagged byte closes the record.
   task automatic parse_byte(input logic [7:0] b, input logic last);
      int unsigned       idx;
      parsed_record_type rec;
      idx = pr_index;
      if (idx < 4) begin
         if (b != MAGIC[idx[1:0]]) pr_header_good = 1'b0;
      end else if (idx == 4) begin
         if (b != HDR_VERSION) pr_header_good = 1'b0;
      end else if (idx == 5) begin
         pr_kind = b;
      end else if (idx == 6) begin
         pr_code = b;
      end else if (idx == 7) begin
         pr_format = b;
      end else if (idx < 16) begin
         pr_challenge = pr_challenge | (64'(b) << (8 * (idx - 8)));
      end else if (idx < 20) begin
         pr_seconds = pr_seconds | (32'(b) << (8 * (idx - 16)));
      end else if (idx < RecLen) begin
         if (b != 0) pr_tail_clear = 1'b0;
      end
      // hold the count at its ceiling on overlong records
      if (pr_index < IDX_MAX) pr_index = pr_index + 1'b1;
      if (last) begin
         rec.fields = '0;
         if (idx + 1 != RecLen) begin
            rec.status = STATUS_BAD_LEN;
         end else if (!pr_header_good || !pr_tail_clear || !kind_rules_met()) begin
            rec.status = STATUS_MALFORMED;
         end else begin
            rec.status                = STATUS_OK;
            rec.fields.record_kind    = pr_kind;
            rec.fields.reply_code     = pr_code;
            rec.fields.time_format    = pr_format;
            rec.fields.challenge      = pr_challenge;
            rec.fields.second_of_day  = pr_seconds;
         end
         awaited_records.push_back(rec);
         // drop back to the reset state for the next record
         pr_index       = '0;
         pr_header_good = 1'b1;
         pr_tail_clear  = 1'b1;
         pr_kind        = '0;
         pr_code        = '0;
         pr_format      = '0;
         pr_challenge   = '0;
         pr_seconds     = '0;
      end
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, seen);
         fail_count = fail_count + 1;
      end
   endfunction

   // Fill the record buffer with a well-formed header and the given content;
   // bytes past offset 23 are random filler for overlong records.
   task automatic build_record(input logic [7:0] kind, input logic [7:0] code,
                               input logic [7:0] fmt, input logic [63:0] chal,
                               input logic [31:0] sec);
      int i;
      for (i = 0; i < 48; i++) rec_bytes[i] = 8'($urandom);
      for (i = 0; i < 4; i++) rec_bytes[i] = MAGIC[i];
      rec_bytes[4] = HDR_VERSION;
      rec_bytes[5] = kind;
      rec_bytes[6] = code;
      rec_bytes[7] = fmt;
      for (i = 0; i < 8; i++) rec_bytes[8 + i] = chal[8 * i +: 8];
      for (i = 0; i < 4; i++) rec_bytes[16 + i] = sec[8 * i +: 8];
      for (i = 20; i < 24; i++) rec_bytes[i] = 8'h00;
   endtask

   // Queue the first len bytes of the buffer, flagging the final one.
   task automatic queue_record(input int len);
      int            i;
      byte_item_type item;
      for (i = 0; i < len; i++) begin
         item.data = rec_bytes[i];
         item.last = (i == len - 1);
         pending_bytes.push_back(item);
      end
   endtask

   // Mostly valid records per kind with random content, some with one flaw,
   // some cut short or run long.
   task automatic queue_random_record();
      logic [7:0]  kind;
      logic [7:0]  code;
      logic [7:0]  fmt;
      logic [63:0] chal;
      logic [31:0] sec;
      int          flaw;
      int          shape;
      int          len;
      kind = 8'($urandom_range(1, 4));
      code = 8'h00;
      fmt  = FMT_NONE;
      chal = {$urandom, $urandom};
      if (chal == 0) chal = 64'd1;
      sec  = '0;
      case (kind)
         KIND_SYNC: chal = '0;
         KIND_TIME: begin
            fmt = 8'($urandom_range(1, 2));
            sec = $urandom_range(0, 86399);
         end
         KIND_REPLY: begin
            code = 8'($urandom_range(0, 8));
            if ($urandom_range(0, 3) == 0) chal = '0;
         end
         default: ;
      endcase
      flaw = ($urandom_range(0, 99) < 40) ? $urandom_range(0, 9) : -1;
      case (flaw)
         0: code = 8'($urandom);
         1: code = CODE_MAX + 8'd1;
         2: fmt  = 8'($urandom);
         3: sec  = $urandom;
         4: sec  = SECONDS_PER_DAY;
         5: chal = '0;
         6: kind = 8'($urandom);
         default: ;
      endcase
      build_record(kind, code, fmt, chal, sec);
      case (flaw)
         7: rec_bytes[$urandom_range(0, 3)] = 8'($urandom);
         8: rec_bytes[4] = 8'($urandom);
         9: rec_bytes[$urandom_range(20, 23)] = 8'($urandom_range(1, 255));
         default: ;
      endcase
      shape = $urandom_range(0, 99);
      if (shape < 75)      len = RecLen;
      else if (shape < 88) len = $urandom_range(1, RecLen - 1);
      else                 len = $urandom_range(RecLen + 1, 40);
      queue_record(len);
   endtask

   // Driver: present the next queued byte once the current one is taken,
   // idle at random outside the calm window, and stall the result side likewise.
   always @(posedge clock) begin : drive_bytes
      byte_item_type item;
      logic          calm;
      if (reset) begin
         req_tvalid  <= 1'b0;
         rsp_tready  <= 1'b0;
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         calm = (cycle_count >= CalmStart) && (cycle_count < CalmEnd);
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
               item = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.data;
               req_tlast  <= item.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= 29);
      end
   end

   // Monitor: compare each result transaction with the oldest prediction,
   // then feed each accepted byte to the predictor; watch for a hang.
   always @(posedge clock) begin : watch_records
      parsed_record_type want;
      rec_fields_type    got;
      logic              moved;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         moved = 1'b0;
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            got   = rec_fields_type'(rsp_tdata);
            if (awaited_records.size() == 0) begin
               $error("result with none awaited: status %0d, data %0h", rsp_tuser, rsp_tdata);
               fail_count = fail_count + 1;
            end else begin
               want = awaited_records.pop_front();
               check_field("status",        64'(want.status),               64'(rsp_tuser));
               check_field("record_kind",   64'(want.fields.record_kind),   64'(got.record_kind));
               check_field("reply_code",    64'(want.fields.reply_code),    64'(got.reply_code));
               check_field("time_format",   64'(want.fields.time_format),   64'(got.time_format));
               check_field("challenge",     want.fields.challenge,          got.challenge);
               check_field("second_of_day", 64'(want.fields.second_of_day), 64'(got.second_of_day));
            end
         end
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            parse_byte(req_tdata, req_tlast);
         end
         if (moved) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= StallLimit) begin
            $display("FAIL");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin : run_test
      int unsigned start_bytes;
      int unsigned n_records;

      // Directed records: one valid record of each kind at its limits.
      build_record(KIND_SYNC, 8'h00, FMT_NONE, 64'h0, 32'h0);
      queue_record(RecLen);
      build_record(KIND_PROBE, 8'h00, FMT_NONE, '1, 32'h0);
      queue_record(RecLen);
      build_record(KIND_TIME, 8'h00, FMT_UTC, 64'h8000_0000_0000_0000, 32'd86399);
      queue_record(RecLen);
      build_record(KIND_REPLY, CODE_MAX, FMT_NONE, 64'h0, 32'h0);
      queue_record(RecLen);
      // second of day one past the end of the day
      build_record(KIND_TIME, 8'h00, FMT_LOCAL, 64'h1, SECONDS_PER_DAY);
      queue_record(RecLen);
      // code one above its ceiling
      build_record(KIND_REPLY, CODE_MAX + 8'd1, FMT_NONE, '1, 32'h0);
      queue_record(RecLen);
      // reply with neither code nor challenge
      build_record(KIND_REPLY, 8'h00, FMT_NONE, 64'h0, 32'h0);
      queue_record(RecLen);
      // broken magic, broken version, nonzero tail
      build_record(KIND_SYNC, 8'h00, FMT_NONE, 64'h0, 32'h0);
      rec_bytes[3] = 8'h00;
      queue_record(RecLen);
      build_record(KIND_SYNC, 8'h00, FMT_NONE, 64'h0, 32'h0);
      rec_bytes[4] = 8'h00;
      queue_record(RecLen);
      build_record(KIND_SYNC, 8'h00, FMT_NONE, 64'h0, 32'h0);
      rec_bytes[23] = 8'hFF;
      queue_record(RecLen);
      // unknown kinds at both ends of the byte
      build_record(8'h00, 8'h00, FMT_NONE, 64'h0, 32'h0);
      queue_record(RecLen);
      build_record(8'hFF, 8'hFF, 8'hFF, '1, '1);
      queue_record(RecLen);
      // wrong lengths: a lone flagged byte, one short, one long, saturating count
      build_record(KIND_SYNC, 8'h00, FMT_NONE, 64'h0, 32'h0);
      rec_bytes[0] = 8'hFF;
      queue_record(1);
      build_record(KIND_SYNC, 8'h00, FMT_NONE, 64'h0, 32'h0);
      queue_record(RecLen - 1);
      build_record(KIND_SYNC, 8'h00, FMT_NONE, 64'h0, 32'h0);
      queue_record(RecLen + 1);
      build_record(KIND_PROBE, 8'h00, FMT_NONE, 64'h5, 32'h0);
      queue_record(40);

      // Random records until both the byte count and the record count are met.
      start_bytes = pending_bytes.size();
      n_records   = 0;
      while (pending_bytes.size() - start_bytes < RandomBytes || n_records < RandomRecords) begin
         queue_random_record();
         n_records++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last byte to go out, then for every result to arrive.
      while (pending_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (awaited_records.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
